// File: sv/sorted_insert_list_defines.svh
// assertion macros for the sorted insert list
`ifndef SORTED_INSERT_LIST_DEFINES_SVH
`define SORTED_INSERT_LIST_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising edge outside reset
`define SIL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SIL_ASSERT_NOW(lbl, ante, cons, msg)
`define SIL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/sil_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sil_pkg;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_COUNT  = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  // request payload
  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } sil_req_t;

  // result payload
  typedef struct packed {
    logic signed [31:0] data_value;
    logic [4:0]         entry_count;
    logic               last;
    logic [1:0]         status;
  } sil_res_t;

  // what the output register is loaded with
  typedef enum logic [2:0] {
    SEL_INSERT = 3'd0,
    SEL_FULL   = 3'd1,
    SEL_COUNT  = 3'd2,
    SEL_EMPTY  = 3'd3,
    SEL_ENTRY  = 3'd4
  } sil_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     do_insert;
    logic     do_rotate;
    logic     clear_idx;
    logic     load_out;
    sil_sel_t sel;
  } sil_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic dump_last;
  } sil_stat_t;

endpackage

`default_nettype wire

// File: sv/sorted_insert_list.sv
// channel  | valid      | ready      | payload
// request  | req_valid  | req_ready  | req (command, value)
// result   | res_valid  | res_ready  | res (data_value, entry_count, last, status)
//
// insert and count are registered; the next request can be taken in the following cycle
// a dump of a non-empty store first clears the dump position, then reads one entry a
// cycle while the result is not stalled, from the head cell as the occupied cells
// rotate; requests are held off until the last entry is loaded
// reset clears occupancy, controller state and the result valid; cells are not cleared
// a stalled result holds the output register and, from it, the request side
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_insert_list_defines.svh"

module sorted_insert_list import sil_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire sil_req_t req,
  output logic          res_valid,
  input  wire logic     res_ready,
  output sil_res_t      res
);

  sil_cmd_t  cmd;
  sil_stat_t stat;
  logic      ins_acc_ok;
  logic      ins_res_ok;

  // sequencing
  sil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .command   (req.command),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // cell row, occupancy and output register
  sil_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk   (clk),
    .rst   (rst),
    .value (req.value),
    .cmd   (cmd),
    .stat  (stat),
    .res   (res)
  );

  // terms for the insert check
  assign ins_acc_ok = req_valid && req_ready && (req.command == CMD_INSERT) && !stat.full;
  assign ins_res_ok = res_valid && res.last && (res.status == STS_OK);

  // checks
  `SIL_ASSERT_NOW(a_no_req_in_dump, cmd.do_rotate, !req_ready, "request taken during dump")
  `SIL_ASSERT_NOW(a_no_insert_full, stat.full, !cmd.do_insert, "insert into full store")
  `SIL_ASSERT_NEXT(a_dump_ends, cmd.do_rotate && stat.dump_last, !cmd.do_rotate, "dump overran")
  `SIL_ASSERT_NEXT(a_insert_ok, ins_acc_ok, ins_res_ok, "insert result wrong")

endmodule

`default_nettype wire

// File: sv/sil_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module sil_dpath import sil_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [31:0] value,
  input  wire sil_cmd_t           cmd,
  output sil_stat_t               stat,
  output sil_res_t                res
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // row of cells holding the sorted entries, cell 0 smallest
  logic signed [31:0] cells [DEPTH];
  logic [DEPTH-1:0]   less;
  logic [CNT_W-1:0]   n;
  logic [CNT_W-1:0]   n_plus;
  logic [CNT_W-1:0]   last_idx;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W+4:0]   n_ext;
  logic [CNT_W+4:0]   n_plus_ext;

  assign n_plus     = n + CNT_W'(1);
  assign last_idx   = n - CNT_W'(1);
  assign n_ext      = {5'b0, n};
  assign n_plus_ext = {5'b0, n_plus};

  assign stat.full      = (n == CNT_W'(DEPTH));
  assign stat.empty     = (n == '0);
  assign stat.dump_last = (CNT_W'(idx) == last_idx);

  // per-cell compare: stored entry is smaller than the new value
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign less[i] = (CNT_W'(i) < n) && (cells[i] < value);

    always_ff @(posedge clk) begin
      if (cmd.do_insert) begin
        if (!less[i]) begin
          if (i == 0) begin
            cells[i] <= value;
          end else if (less[(i == 0) ? 0 : i-1]) begin
            cells[i] <= value;
          end else begin
            cells[i] <= cells[(i == 0) ? 0 : i-1];
          end
        end
      end else if (cmd.do_rotate) begin
        // rotate the occupied part left by one, head wraps to the tail
        if (i == DEPTH - 1) begin
          cells[i] <= cells[0];
        end else if (CNT_W'(i) == last_idx) begin
          cells[i] <= cells[0];
        end else begin
          cells[i] <= cells[(i == DEPTH - 1) ? i : i+1];
        end
      end
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (cmd.do_insert) begin
      n <= n_plus;
    end
  end

  // dump position
  always_ff @(posedge clk) begin
    if (cmd.clear_idx) begin
      idx <= '0;
    end else if (cmd.do_rotate) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd.sel)
        SEL_INSERT: begin
          res <= '{data_value: value, entry_count: n_plus_ext[4:0], last: 1'b1,
                   status: STS_OK};
        end
        SEL_FULL: begin
          res <= '{data_value: value, entry_count: n_ext[4:0], last: 1'b1,
                   status: STS_FULL};
        end
        SEL_COUNT: begin
          res <= '{data_value: '0, entry_count: n_ext[4:0], last: 1'b1,
                   status: STS_OK};
        end
        SEL_EMPTY: begin
          res <= '{data_value: '0, entry_count: 5'd0, last: 1'b1,
                   status: STS_EMPTY};
        end
        SEL_ENTRY: begin
          res <= '{data_value: cells[0], entry_count: n_ext[4:0],
                   last: stat.dump_last, status: STS_OK};
        end
        default: begin
          res <= '{data_value: '0, entry_count: 5'd0, last: 1'b1,
                   status: STS_OK};
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/sil_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sil_ctrl import sil_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire logic [1:0] command,
  output logic            res_valid,
  input  wire logic       res_ready,
  input  wire sil_stat_t  stat,
  output sil_cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   req_acc;

  // output register can take a new result this cycle
  assign slot_free = !res_valid || res_ready;
  assign req_ready = (state == ST_IDLE) && slot_free;
  assign req_acc   = req_valid && req_ready;

  // command decode and sequencing
  always_comb begin
    state_next    = state;
    cmd.do_insert = 1'b0;
    cmd.do_rotate = 1'b0;
    cmd.clear_idx = 1'b0;
    cmd.load_out  = 1'b0;
    cmd.sel       = SEL_INSERT;
    case (state)
      ST_IDLE: begin
        if (req_acc) begin
          case (command)
            CMD_INSERT: begin
              cmd.load_out  = 1'b1;
              cmd.sel       = stat.full ? SEL_FULL : SEL_INSERT;
              cmd.do_insert = !stat.full;
            end
            CMD_COUNT: begin
              cmd.load_out = 1'b1;
              cmd.sel      = SEL_COUNT;
            end
            CMD_DUMP: begin
              if (stat.empty) begin
                cmd.load_out = 1'b1;
                cmd.sel      = SEL_EMPTY;
              end else begin
                cmd.clear_idx = 1'b1;
                state_next    = ST_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          cmd.sel       = SEL_ENTRY;
          cmd.do_rotate = 1'b1;
          if (stat.dump_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
